// File: hw/rtl/countdown_event_timer_table_top_macros.svh
// ----------------------------------------------------------------------------
// Countdown event timer table: assertion macros
// Shared property forms for the timer table checks.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_EVENT_TIMER_TABLE_TOP_MACROS_SVH
`define COUNTDOWN_EVENT_TIMER_TABLE_TOP_MACROS_SVH

// Same-cycle implication, quiet while in reset
`define CETT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while in reset
`define CETT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cett_pkg.sv
// ----------------------------------------------------------------------------
// cett_pkg
// Types and constants shared by the countdown event timer table.
// ----------------------------------------------------------------------------
package cett_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned CD_W      = 8;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned TICK_W    = 32;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_TICK     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE_NEW,
    CMD_RELOAD,
    CMD_TICK
  } cmd_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SWEEP,
    ENG_FINISH
  } eng_state_e;

  typedef struct packed {
    cmd_e              kind;
    status_e           status;
    logic [ID_W-1:0]   ident;
    logic [CD_W-1:0]   value;
    logic [TICK_W-1:0] ticks;
  } cmd_t;

endpackage

// File: hw/rtl/countdown_event_timer_table_top.sv
// ----------------------------------------------------------------------------
// countdown_event_timer_table_top
// Table of event slots with 8-bit countdowns, reloads and table-wide ticks.
//
// Channel  Dir  Signals                    Content
// s_axis   in   tvalid tready tdata tuser  add, schedule or tick item
// m_axis   out  tvalid tready tdata tuser  one result per item
//
// Add, schedule and unused opcodes are applied and their result loaded when popped.
// A tick walks the held entries through one read port: pop, one read per entry, last
// write-back, drain, result load; an empty table loads its result when popped.
// The front keeps accepting while the two-entry queue has room.
// Reset clears counts, queue and engine; slot memories need no clearing pass.
// A stalled result stays in the output register; the engine waits on it.
// ----------------------------------------------------------------------------
`include "countdown_event_timer_table_top_macros.svh"

module countdown_event_timer_table_top #(
  parameter int unsigned SLOTS = cett_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_id[15:0] countdown[23:16] slot_index[29:24]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // event_id[15:0] entry_count[22:16] tick_count[54:23]
  output logic [2:0]  m_axis_tuser   // status[1:0] event_fired[2]
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW = CW + AW + $bits(cett_pkg::cmd_t);
  localparam logic [cett_pkg::OUT_CNT_W-1:0] CNT_CAP = cett_pkg::OUT_CNT_W'(SLOTS);

  cett_pkg::cmd_t    f_cmd, e_cmd;
  logic [CW-1:0]     f_cnt, e_cnt;
  logic [AW-1:0]     f_addr, e_addr;
  logic              f_push, q_ready, q_valid, q_pop;
  logic [QW-1:0]     q_wdata, q_rdata;

  cett_pkg::status_e                out_status;
  logic                             out_fired;
  logic [cett_pkg::ID_W-1:0]        out_id;
  logic [cett_pkg::OUT_CNT_W-1:0]   out_cnt;
  logic [cett_pkg::TICK_W-1:0]      out_ticks;

  logic                             rep_full, rep_fired, rep_ok;

  cett_front #(
    .SLOTS (SLOTS),
    .CW    (CW),
    .AW    (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_ident_i   (s_axis_tdata[15:0]),
    .in_value_i   (s_axis_tdata[23:16]),
    .in_slot_i    (s_axis_tdata[29:24]),
    .push_o       (f_push),
    .push_ready_i (q_ready),
    .cmd_o        (f_cmd),
    .cnt_o        (f_cnt),
    .addr_o       (f_addr)
  );

  assign q_wdata = {f_cnt, f_addr, f_cmd};
  assign {e_cnt, e_addr, e_cmd} = q_rdata;

  cett_queue #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_push),
    .push_ready_o (q_ready),
    .data_i       (q_wdata),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .data_o       (q_rdata)
  );

  cett_engine #(
    .SLOTS (SLOTS),
    .CW    (CW),
    .AW    (AW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .cmd_i        (e_cmd),
    .cnt_i        (e_cnt),
    .addr_i       (e_addr),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_fired_o  (out_fired),
    .out_id_o     (out_id),
    .out_cnt_o    (out_cnt),
    .out_ticks_o  (out_ticks)
  );

  assign m_axis_tdata = {1'b0, out_ticks, out_cnt, out_id};
  assign m_axis_tuser = {out_fired, out_status};

  assign rep_full  = m_axis_tvalid & (out_status == cett_pkg::ST_FULL);
  assign rep_fired = m_axis_tvalid & out_fired;
  assign rep_ok    = (out_status == cett_pkg::ST_OK);

  `CETT_ASSERT_IMP(a_full_at_cap, rep_full, out_cnt == CNT_CAP, "full reported below capacity")
  `CETT_ASSERT_IMP(a_fire_only_ok, rep_fired, rep_ok, "event fired on a rejected item")
  `CETT_ASSERT_IMP(a_pop_nonempty, q_pop, q_valid, "engine popped an empty queue")

endmodule

// File: hw/rtl/cett_front.sv
// ----------------------------------------------------------------------------
// cett_front
// Accepts items, checks them against the held count and issues commands.
// ----------------------------------------------------------------------------
module cett_front #(
  parameter int unsigned SLOTS = cett_pkg::SLOTS_DEF,
  parameter int unsigned CW    = $clog2(SLOTS + 1),
  parameter int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    in_op_i,
  input  logic [cett_pkg::ID_W-1:0]     in_ident_i,
  input  logic [cett_pkg::CD_W-1:0]     in_value_i,
  input  logic [cett_pkg::SLOT_W-1:0]   in_slot_i,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output cett_pkg::cmd_t                cmd_o,
  output logic [CW-1:0]                 cnt_o,
  output logic [AW-1:0]                 addr_o
);

  localparam int unsigned CMPW = (CW > cett_pkg::SLOT_W) ? CW : cett_pkg::SLOT_W;

  logic [CW-1:0]               count_q, count_d;
  logic [cett_pkg::TICK_W-1:0] ticks_q, ticks_d;
  logic [CMPW-1:0]             slot_ext;
  logic                        accept;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i;
  assign accept     = in_valid_i & push_ready_i;
  assign slot_ext   = CMPW'(in_slot_i);

  always_comb begin
    count_d      = count_q;
    ticks_d      = ticks_q;
    addr_o       = count_q[AW-1:0];
    cmd_o.kind   = cett_pkg::CMD_NONE;
    cmd_o.status = cett_pkg::ST_OK;
    cmd_o.ident  = in_ident_i;
    cmd_o.value  = in_value_i;
    case (in_op_i)
      cett_pkg::OP_ADD: begin
        if (count_q == CW'(SLOTS)) begin
          cmd_o.status = cett_pkg::ST_FULL;
        end else begin
          cmd_o.kind = cett_pkg::CMD_WRITE_NEW;
          count_d    = count_q + CW'(1);
        end
      end
      cett_pkg::OP_SCHEDULE: begin
        if (slot_ext < CMPW'(count_q)) begin
          cmd_o.kind = cett_pkg::CMD_RELOAD;
          addr_o     = slot_ext[AW-1:0];
        end else begin
          cmd_o.status = cett_pkg::ST_RANGE;
        end
      end
      cett_pkg::OP_TICK: begin
        cmd_o.kind = cett_pkg::CMD_TICK;
        ticks_d    = ticks_q + cett_pkg::TICK_W'(1);
      end
      default: begin
      end
    endcase
    cmd_o.ticks = ticks_d;
    cnt_o       = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ticks_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

// File: hw/rtl/cett_queue.sv
// ----------------------------------------------------------------------------
// cett_queue
// Two-entry command queue between the front and the engine.
// ----------------------------------------------------------------------------
module cett_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         push_ready_o,
  input  logic [W-1:0] data_i,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] buf_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   fill_q;
  logic         do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign data_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// File: hw/rtl/cett_engine.sv
// ----------------------------------------------------------------------------
// cett_engine
// Holds the slot memories, applies commands and sweeps the table on a tick.
// ----------------------------------------------------------------------------
module cett_engine #(
  parameter int unsigned SLOTS = cett_pkg::SLOTS_DEF,
  parameter int unsigned CW    = $clog2(SLOTS + 1),
  parameter int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  output logic                             q_pop_o,
  input  cett_pkg::cmd_t                   cmd_i,
  input  logic [CW-1:0]                    cnt_i,
  input  logic [AW-1:0]                    addr_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cett_pkg::status_e                out_status_o,
  output logic                             out_fired_o,
  output logic [cett_pkg::ID_W-1:0]        out_id_o,
  output logic [cett_pkg::OUT_CNT_W-1:0]   out_cnt_o,
  output logic [cett_pkg::TICK_W-1:0]      out_ticks_o
);

  logic [cett_pkg::ID_W-1:0] ident_mem [SLOTS];
  logic [cett_pkg::CD_W-1:0] rem_mem   [SLOTS];

  cett_pkg::eng_state_e state_q, state_d;

  logic [CW-1:0]               ptr_q, ptr_d;
  logic                        rd_en, rd_vld_q;
  logic [AW-1:0]               rd_addr, rd_addr_q;
  logic [cett_pkg::CD_W-1:0]   rd_rem_q;
  logic [cett_pkg::ID_W-1:0]   rd_ident_q;
  logic                        fired_q, fired_d;
  logic [cett_pkg::ID_W-1:0]   ev_q, ev_d;
  logic [CW-1:0]               tk_cnt_q;
  logic [cett_pkg::TICK_W-1:0] tk_ticks_q;
  logic                        tk_load;

  logic                        wr_rem_en, wr_ident_en;
  logic [AW-1:0]               wr_addr;
  logic [cett_pkg::CD_W-1:0]   wr_rem_data;

  logic                             out_vld_q, out_free, load;
  cett_pkg::status_e                ld_status, out_status_q;
  logic                             ld_fired, out_fired_q;
  logic [cett_pkg::ID_W-1:0]        ld_id, out_id_q;
  logic [cett_pkg::OUT_CNT_W-1:0]   ld_cnt, out_cnt_q;
  logic [cett_pkg::TICK_W-1:0]      ld_ticks, out_ticks_q;

  assign out_free = ~out_vld_q | out_ready_i;

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    ptr_d       = ptr_q;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[AW-1:0];
    wr_rem_en   = 1'b0;
    wr_ident_en = 1'b0;
    wr_addr     = addr_i;
    wr_rem_data = cmd_i.value;
    fired_d     = fired_q;
    ev_d        = ev_q;
    tk_load     = 1'b0;
    load        = 1'b0;
    ld_status   = cmd_i.status;
    ld_fired    = 1'b0;
    ld_id       = '0;
    ld_cnt      = cett_pkg::OUT_CNT_W'(cnt_i);
    ld_ticks    = cmd_i.ticks;
    case (state_q)
      cett_pkg::ENG_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (cmd_i.kind)
            cett_pkg::CMD_WRITE_NEW: begin
              wr_rem_en   = 1'b1;
              wr_ident_en = 1'b1;
              load        = 1'b1;
            end
            cett_pkg::CMD_RELOAD: begin
              wr_rem_en = 1'b1;
              load      = 1'b1;
            end
            cett_pkg::CMD_TICK: begin
              if (cnt_i == '0) begin
                load = 1'b1;
              end else begin
                tk_load = 1'b1;
                ptr_d   = '0;
                fired_d = 1'b0;
                ev_d    = '0;
                state_d = cett_pkg::ENG_SWEEP;
              end
            end
            default: load = 1'b1;
          endcase
        end
      end
      cett_pkg::ENG_SWEEP: begin
        if (rd_vld_q && (rd_rem_q != '0)) begin
          wr_rem_en   = 1'b1;
          wr_addr     = rd_addr_q;
          wr_rem_data = rd_rem_q - cett_pkg::CD_W'(1);
          if ((rd_rem_q == cett_pkg::CD_W'(1)) && !fired_q) begin
            fired_d = 1'b1;
            ev_d    = rd_ident_q;
          end
        end
        if (ptr_q != tk_cnt_q) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + CW'(1);
        end else if (!rd_vld_q) begin
          state_d = cett_pkg::ENG_FINISH;
        end
      end
      cett_pkg::ENG_FINISH: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = cett_pkg::ST_OK;
          ld_fired  = fired_q;
          ld_id     = ev_q;
          ld_cnt    = cett_pkg::OUT_CNT_W'(tk_cnt_q);
          ld_ticks  = tk_ticks_q;
          state_d   = cett_pkg::ENG_IDLE;
        end
      end
      default: state_d = cett_pkg::ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_rem_en) begin
      rem_mem[wr_addr] <= wr_rem_data;
    end
    if (wr_ident_en) begin
      ident_mem[wr_addr] <= cmd_i.ident;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_rem_q   <= rem_mem[rd_addr];
      rd_ident_q <= ident_mem[rd_addr];
      rd_addr_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tk_load) begin
      tk_cnt_q   <= cnt_i;
      tk_ticks_q <= cmd_i.ticks;
    end
    if (load) begin
      out_status_q <= ld_status;
      out_fired_q  <= ld_fired;
      out_id_q     <= ld_id;
      out_cnt_q    <= ld_cnt;
      out_ticks_q  <= ld_ticks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cett_pkg::ENG_IDLE;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      fired_q   <= 1'b0;
      ev_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_en;
      fired_q  <= fired_d;
      ev_q     <= ev_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_fired_o  = out_fired_q;
  assign out_id_o     = out_id_q;
  assign out_cnt_o    = out_cnt_q;
  assign out_ticks_o  = out_ticks_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the countdown event timer table against a cycle-free predictor.
// It opens with a short table of adds, schedules, ticks and unused opcodes.
// A random stream follows that fills the table, overruns it, reloads slots
// and ticks entries down to expiry. Both stream sides idle at random, and
// one long result hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned TABLE_SLOTS  = cett_pkg::SLOTS_DEF;
  localparam int          RANDOM_ITEMS = 1400;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 2 * TABLE_SLOTS + 20;
  localparam int          HOLD_AFTER   = 300;
  localparam int          HOLD_CYCLES  = 500;

  typedef enum {RX_OPEN, RX_BUSY, RX_SLOW} rx_mode_e;

  typedef struct packed {
    cett_pkg::status_e               status;
    logic                            fired;
    logic [cett_pkg::ID_W-1:0]       ev_id;
    logic [cett_pkg::OUT_CNT_W-1:0]  count;
    logic [cett_pkg::TICK_W-1:0]     ticks;
  } timer_result_t;

  typedef struct packed {
    logic [1:0]                      op;
    logic [cett_pkg::ID_W-1:0]       ident;
    logic [cett_pkg::CD_W-1:0]       cd;
    logic [cett_pkg::SLOT_W-1:0]     slot;
    logic                            typed;
    timer_result_t                   res;
  } plan_row_t;

  localparam plan_row_t PLAN [22] = '{
    '{cett_pkg::OP_TICK,     16'h0000, 8'h00, 6'd0,  1'b1,
      '{cett_pkg::ST_OK,    1'b0, 16'h0000, 7'd0, 32'd1}},
    '{cett_pkg::OP_SCHEDULE, 16'h0000, 8'h05, 6'd0,  1'b1,
      '{cett_pkg::ST_RANGE, 1'b0, 16'h0000, 7'd0, 32'd1}},
    '{OP_UNUSED,             16'hffff, 8'hff, 6'd63, 1'b1,
      '{cett_pkg::ST_OK,    1'b0, 16'h0000, 7'd0, 32'd1}},
    '{cett_pkg::OP_ADD,      16'hffff, 8'hff, 6'd63, 1'b1,
      '{cett_pkg::ST_OK,    1'b0, 16'h0000, 7'd1, 32'd1}},
    '{cett_pkg::OP_ADD,      16'h0000, 8'h01, 6'd0,  1'b1,
      '{cett_pkg::ST_OK,    1'b0, 16'h0000, 7'd2, 32'd1}},
    '{cett_pkg::OP_ADD,      16'h1234, 8'h00, 6'd0,  1'b1,
      '{cett_pkg::ST_OK,    1'b0, 16'h0000, 7'd3, 32'd1}},
    '{cett_pkg::OP_TICK,     16'h0000, 8'h00, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_TICK,     16'h0000, 8'h00, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_SCHEDULE, 16'h0000, 8'h00, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_SCHEDULE, 16'h0000, 8'h07, 6'd3,  1'b1,
      '{cett_pkg::ST_RANGE, 1'b0, 16'h0000, 7'd3, 32'd3}},
    '{cett_pkg::OP_SCHEDULE, 16'h0000, 8'hff, 6'd63, 1'b1,
      '{cett_pkg::ST_RANGE, 1'b0, 16'h0000, 7'd3, 32'd3}},
    '{cett_pkg::OP_TICK,     16'h0000, 8'h00, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_ADD,      16'ha5a5, 8'h02, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_ADD,      16'h5a5a, 8'h01, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_SCHEDULE, 16'h0000, 8'h02, 6'd4,  1'b0, '0},
    '{cett_pkg::OP_SCHEDULE, 16'h0000, 8'h02, 6'd2,  1'b0, '0},
    '{cett_pkg::OP_TICK,     16'h0000, 8'h00, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_TICK,     16'h0000, 8'h00, 6'd0,  1'b0, '0},
    '{OP_UNUSED,             16'h0000, 8'h00, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_ADD,      16'h8000, 8'h80, 6'd0,  1'b0, '0},
    '{cett_pkg::OP_SCHEDULE, 16'h0000, 8'h01, 6'd5,  1'b0, '0},
    '{cett_pkg::OP_TICK,     16'h0000, 8'h00, 6'd0,  1'b0, '0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [55:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;

  // typed expectation travelling with the item on the input
  logic          typed_now = 1'b0;
  timer_result_t typed_res = '0;

  logic [cett_pkg::ID_W-1:0]   slot_ident_q [TABLE_SLOTS];
  logic [cett_pkg::CD_W-1:0]   slot_left_q  [TABLE_SLOTS];
  int unsigned                 held_entries = 0;
  logic [cett_pkg::TICK_W-1:0] tick_total   = '0;
  timer_result_t               pending_q [$];

  int errors       = 0;
  int results_seen = 0;
  int items_sent   = 0;
  int adds_taken   = 0;
  int full_refused = 0;
  int range_refused = 0;
  int expiries     = 0;
  int cycle_count  = 0;

  countdown_event_timer_table_top #(
    .SLOTS(TABLE_SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic timer_result_t apply_timer_item(logic [1:0] op,
                                                     logic [cett_pkg::ID_W-1:0] ident,
                                                     logic [cett_pkg::CD_W-1:0] cd,
                                                     logic [cett_pkg::SLOT_W-1:0] slot);
    timer_result_t r;
    int unsigned   i;
    r = '0;
    case (op)
      cett_pkg::OP_ADD: begin
        if (held_entries >= TABLE_SLOTS) begin
          r.status = cett_pkg::ST_FULL;
          full_refused++;
        end else begin
          slot_ident_q[held_entries] = ident;
          slot_left_q[held_entries]  = cd;
          held_entries++;
          adds_taken++;
        end
      end
      cett_pkg::OP_SCHEDULE: begin
        if (slot < held_entries) begin
          slot_left_q[slot] = cd;
        end else begin
          r.status = cett_pkg::ST_RANGE;
          range_refused++;
        end
      end
      cett_pkg::OP_TICK: begin
        tick_total++;
        // decrement every live countdown, report only the lowest expiry
        for (i = 0; i < held_entries; i++) begin
          if (slot_left_q[i] != '0) begin
            slot_left_q[i]--;
            if (slot_left_q[i] == '0 && !r.fired) begin
              r.fired = 1'b1;
              r.ev_id = slot_ident_q[i];
            end
          end
        end
        if (r.fired) expiries++;
      end
      default: ;
    endcase
    r.count = cett_pkg::OUT_CNT_W'(held_entries);
    r.ticks = tick_total;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    timer_result_t seen;
    timer_result_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen = apply_timer_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
                              s_axis_tdata[29:24]);
      pending_q.push_back(typed_now ? typed_res : seen);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      seen.status = cett_pkg::status_e'(m_axis_tuser[1:0]);
      seen.fired  = m_axis_tuser[2];
      seen.ev_id  = m_axis_tdata[15:0];
      seen.count  = m_axis_tdata[22:16];
      seen.ticks  = m_axis_tdata[54:23];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, seen);
        errors++;
      end else begin
        want = pending_q.pop_front();
        check_field("status", 32'(want.status), 32'(seen.status));
        check_field("event_fired", 32'(want.fired), 32'(seen.fired));
        check_field("event_id", 32'(want.ev_id), 32'(seen.ev_id));
        check_field("entry_count", 32'(want.count), 32'(seen.count));
        check_field("tick_count", want.ticks, seen.ticks);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int       seg_left;
    int       hold_left;
    bit       hold_done;
    rx_mode_e mode;
    seg_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    mode      = RX_OPEN;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        mode     = rx_mode_e'($urandom_range(0, 2));
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: m_axis_tready <= 1'b1;
          RX_BUSY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [cett_pkg::ID_W-1:0] ident,
                           logic [cett_pkg::CD_W-1:0] cd,
                           logic [cett_pkg::SLOT_W-1:0] slot, logic typed,
                           timer_result_t res);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, slot, cd, ident};
    typed_now     <= typed;
    typed_res     <= res;
    items_sent++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  initial begin : stimulus
    int                          burst_left;
    int                          gen_held;
    int                          counted;
    int                          pick;
    logic [1:0]                  op;
    logic [cett_pkg::ID_W-1:0]   ident;
    logic [cett_pkg::CD_W-1:0]   cd;
    logic [cett_pkg::SLOT_W-1:0] slot;
    gen_held   = 0;
    burst_left = 0;
    counted    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[r]) begin
      if (PLAN[r].op == cett_pkg::OP_ADD) gen_held++;
      send_item(PLAN[r].op, PLAN[r].ident, PLAN[r].cd, PLAN[r].slot, PLAN[r].typed,
                PLAN[r].res);
    end

    while (counted < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      // favour adds until the table is full, then reloads and ticks
      pick = $urandom_range(0, 99);
      if (pick < 5) op = OP_UNUSED;
      else if (pick < ((gen_held < TABLE_SLOTS) ? 50 : 15)) op = cett_pkg::OP_ADD;
      else if (pick < ((gen_held < TABLE_SLOTS) ? 70 : 55)) op = cett_pkg::OP_SCHEDULE;
      else op = cett_pkg::OP_TICK;
      ident = cett_pkg::ID_W'($urandom);
      pick  = $urandom_range(0, 9);
      if (pick < 6) cd = cett_pkg::CD_W'($urandom_range(1, 6));
      else if (pick < 7) cd = '0;
      else cd = cett_pkg::CD_W'($urandom_range(0, 255));
      slot = cett_pkg::SLOT_W'($urandom_range(0, 63));
      if (op == cett_pkg::OP_SCHEDULE && gen_held > 0 && $urandom_range(0, 9) != 0)
        slot = cett_pkg::SLOT_W'($urandom_range(0, gen_held - 1));
      if (op == cett_pkg::OP_ADD && gen_held < TABLE_SLOTS) gen_held++;
      if (op != OP_UNUSED) counted++;
      send_item(op, ident, cd, slot, 1'b0, '0);
    end
    pause_sender(1);

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("testbench: %0d items sent, %0d results checked, %0d ticks, %0d expiries",
             items_sent, results_seen, tick_total, expiries);
    $display("testbench: %0d entries added, %0d adds refused when full, %0d reloads out of range",
             adds_taken, full_refused, range_refused);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cett_pkg.sv
hw/rtl/cett_front.sv
hw/rtl/cett_queue.sv
hw/rtl/cett_engine.sv
hw/rtl/countdown_event_timer_table_top.sv
bench/testbench.sv
